@@ src/ile_pkg.sv @@
// Shared constants and codes for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int CAPACITY    = 256;
    localparam int VALUE_WIDTH = 32;
    localparam int NODE_W      = $clog2(CAPACITY);
    localparam int COUNT_W     = $clog2(CAPACITY + 1);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ     = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_AT   = 3'd3,
        CMD_DELETE   = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

endpackage

@@ src/indexed_list_engine_top.sv @@
// Indexed list engine: linked node store with head, tail, free chain and length.
//
//  channel | signals                              | dir
//  --------+--------------------------------------+-----
//  in      | in_valid in_ready cmd position value | in
//  out     | out_valid out_ready status           | out
//          | read_value list_length               |
//
// One item at a time. Head/tail inserts and unused codes skip the link walk.
// Positional read, insert and delete walk down the link store towards the
// position, one link read per cycle.
// Reset chains the free list at once through per-node link valid bits.
// A finished result waits in the output register; the next item is taken
// while it waits, but a second result stalls until the first is taken.
`timescale 1ns / 1ps

module indexed_list_engine_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ile_pkg::CMD_W-1:0]        cmd,
    input  logic [ile_pkg::COUNT_W-1:0]      position,
    input  logic signed [ile_pkg::VALUE_WIDTH-1:0] value,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ile_pkg::STATUS_W-1:0]     status,
    output logic signed [ile_pkg::VALUE_WIDTH-1:0] read_value,
    output logic [ile_pkg::COUNT_W-1:0]      list_length
);

    import ile_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FREE,
        S_WALK0,
        S_WALK,
        S_LOCATE,
        S_RD_WAIT,
        S_INS_SPLICE,
        S_INS_PREV,
        S_DEL_HEAD,
        S_DEL_CUR,
        S_DEL_NEXT,
        S_DEL_FREE,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [CMD_W-1:0]             cmd_reg, cmd_next;
    logic [COUNT_W-1:0]           pos_reg, pos_next;
    logic [COUNT_W-1:0]           ipos_reg, ipos_next;
    logic signed [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [NODE_W-1:0]            first_reg, first_next;
    logic [NODE_W-1:0]            last_reg, last_next;
    logic [NODE_W-1:0]            free_reg, free_next;
    logic [COUNT_W-1:0]           count_reg, count_next;
    logic [NODE_W-1:0]            node_reg, node_next;
    logic [NODE_W-1:0]            prev_reg, prev_next;
    logic [COUNT_W-1:0]           walk_reg, walk_next;
    status_t                      res_status_reg, res_status_next;
    logic signed [VALUE_WIDTH-1:0] res_rd_reg, res_rd_next;

    logic                         out_valid_reg, out_valid_next;
    status_t                      status_reg, status_next;
    logic signed [VALUE_WIDTH-1:0] read_value_reg, read_value_next;
    logic [COUNT_W-1:0]           list_length_reg, list_length_next;

    // link store: registered read, valid bits give the reset chaining
    logic [NODE_W-1:0] link_mem [CAPACITY];
    logic [CAPACITY-1:0] link_vld_reg;
    logic [NODE_W-1:0] link_q;
    logic              link_q_vld;
    logic [NODE_W-1:0] link_q_addr;
    logic [NODE_W-1:0] link_raddr;
    logic              link_we;
    logic [NODE_W-1:0] link_waddr;
    logic [NODE_W-1:0] link_wdata;
    logic [NODE_W-1:0] link_rd;

    // value store
    logic signed [VALUE_WIDTH-1:0] val_mem [CAPACITY];
    logic signed [VALUE_WIDTH-1:0] val_q;
    logic                          val_we;
    logic [NODE_W-1:0]             val_waddr;
    logic [NODE_W-1:0]             val_raddr;

    logic [COUNT_W-1:0] ins_pos;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_q      <= link_mem[link_raddr];
        link_q_addr <= link_raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_vld_reg <= '0;
            link_q_vld   <= 1'b0;
        end
        else
        begin
            if (link_we)
            begin
                link_vld_reg[link_waddr] <= 1'b1;
            end
            link_q_vld <= link_vld_reg[link_raddr];
        end
    end

    // a never-written link still holds its reset chaining i -> i+1
    assign link_rd = link_q_vld ? link_q :
                     (link_q_addr == NODE_W'(CAPACITY - 1)) ? '0 :
                     NODE_W'(link_q_addr + 1'b1);

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[val_waddr] <= val_reg;
        end
        val_q <= val_mem[val_raddr];
    end

    always_comb
    begin
        case (cmd_t'(cmd_reg))
            CMD_INS_HEAD: ins_pos = '0;
            CMD_INS_TAIL: ins_pos = count_reg;
            default:      ins_pos = pos_reg;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        pos_next         = pos_reg;
        ipos_next        = ipos_reg;
        val_next         = val_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        free_next        = free_reg;
        count_next       = count_reg;
        node_next        = node_reg;
        prev_next        = prev_reg;
        walk_next        = walk_reg;
        res_status_next  = res_status_reg;
        res_rd_next      = res_rd_reg;
        out_valid_next   = out_valid_reg;
        status_next      = status_reg;
        read_value_next  = read_value_reg;
        list_length_next = list_length_reg;

        link_raddr = '0;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        val_we     = 1'b0;
        val_waddr  = node_reg;
        val_raddr  = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = cmd;
                    pos_next        = position;
                    val_next        = value;
                    res_status_next = ST_DONE;
                    res_rd_next     = '0;
                    state_next      = S_CHECK;
                end
            end

            S_CHECK:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_READ:
                    begin
                        if (pos_reg >= count_reg)
                        begin
                            res_status_next = ST_INVALID;
                            res_rd_next     = '1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            walk_next  = pos_reg;
                            state_next = S_WALK0;
                        end
                    end

                    CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT:
                    begin
                        if (ins_pos > count_reg)
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_DONE;
                        end
                        else if (count_reg == COUNT_W'(CAPACITY))
                        begin
                            res_status_next = ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            // take the free head and learn its successor
                            link_raddr = free_reg;
                            node_next  = free_reg;
                            val_we     = 1'b1;
                            val_waddr  = free_reg;
                            ipos_next  = ins_pos;
                            state_next = S_FREE;
                        end
                    end

                    CMD_DELETE:
                    begin
                        if (pos_reg >= count_reg)
                        begin
                            res_status_next = ST_INVALID;
                            state_next      = S_DONE;
                        end
                        else if (pos_reg == '0)
                        begin
                            link_raddr = first_reg;
                            node_next  = first_reg;
                            state_next = S_DEL_HEAD;
                        end
                        else
                        begin
                            walk_next  = COUNT_W'(pos_reg - 1'b1);
                            state_next = S_WALK0;
                        end
                    end

                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_FREE:
            begin
                free_next = link_rd;
                if (count_reg == '0)
                begin
                    first_next = node_reg;
                    last_next  = node_reg;
                    count_next = COUNT_W'(count_reg + 1'b1);
                    state_next = S_DONE;
                end
                else if (ipos_reg == '0)
                begin
                    link_we    = 1'b1;
                    link_waddr = node_reg;
                    link_wdata = first_reg;
                    first_next = node_reg;
                    count_next = COUNT_W'(count_reg + 1'b1);
                    state_next = S_DONE;
                end
                else if (ipos_reg == count_reg)
                begin
                    link_we    = 1'b1;
                    link_waddr = last_reg;
                    link_wdata = node_reg;
                    last_next  = node_reg;
                    count_next = COUNT_W'(count_reg + 1'b1);
                    state_next = S_DONE;
                end
                else
                begin
                    walk_next  = COUNT_W'(ipos_reg - 1'b1);
                    state_next = S_WALK0;
                end
            end

            S_WALK0:
            begin
                if (walk_reg == '0)
                begin
                    prev_next  = first_reg;
                    state_next = S_LOCATE;
                end
                else
                begin
                    link_raddr = first_reg;
                    state_next = S_WALK;
                end
            end

            // one link per cycle: the next address comes straight off the read data
            S_WALK:
            begin
                if (walk_reg == COUNT_W'(1))
                begin
                    prev_next  = link_rd;
                    state_next = S_LOCATE;
                end
                else
                begin
                    link_raddr = link_rd;
                    walk_next  = COUNT_W'(walk_reg - 1'b1);
                end
            end

            S_LOCATE:
            begin
                case (cmd_t'(cmd_reg))
                    CMD_READ:
                    begin
                        val_raddr  = prev_reg;
                        state_next = S_RD_WAIT;
                    end
                    CMD_DELETE:
                    begin
                        link_raddr = prev_reg;
                        state_next = S_DEL_CUR;
                    end
                    default:
                    begin
                        link_raddr = prev_reg;
                        state_next = S_INS_SPLICE;
                    end
                endcase
            end

            S_RD_WAIT:
            begin
                res_rd_next = val_q;
                state_next  = S_DONE;
            end

            S_INS_SPLICE:
            begin
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = link_rd;
                state_next = S_INS_PREV;
            end

            S_INS_PREV:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = node_reg;
                count_next = COUNT_W'(count_reg + 1'b1);
                state_next = S_DONE;
            end

            S_DEL_HEAD:
            begin
                first_next = link_rd;
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = free_reg;
                free_next  = node_reg;
                count_next = COUNT_W'(count_reg - 1'b1);
                state_next = S_DONE;
            end

            S_DEL_CUR:
            begin
                node_next  = link_rd;
                link_raddr = link_rd;
                state_next = S_DEL_NEXT;
            end

            S_DEL_NEXT:
            begin
                link_we    = 1'b1;
                link_waddr = prev_reg;
                link_wdata = link_rd;
                if (pos_reg == COUNT_W'(count_reg - 1'b1))
                begin
                    last_next = prev_reg;
                end
                state_next = S_DEL_FREE;
            end

            S_DEL_FREE:
            begin
                link_we    = 1'b1;
                link_waddr = node_reg;
                link_wdata = free_reg;
                free_next  = node_reg;
                count_next = COUNT_W'(count_reg - 1'b1);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next   = 1'b1;
                    status_next      = res_status_reg;
                    read_value_next  = res_rd_reg;
                    list_length_next = count_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= '0;
            last_reg      <= '0;
            free_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pos_reg         <= pos_next;
        ipos_reg        <= ipos_next;
        val_reg         <= val_next;
        node_reg        <= node_next;
        prev_reg        <= prev_next;
        walk_reg        <= walk_next;
        res_status_reg  <= res_status_next;
        res_rd_reg      <= res_rd_next;
        status_reg      <= status_next;
        read_value_reg  <= read_value_next;
        list_length_reg <= list_length_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign read_value  = read_value_reg;
    assign list_length = list_length_reg;

endmodule

@@ src/ile_checker.sv @@
// Port-level checks for the indexed list engine, bound to the top level.
`timescale 1ns / 1ps

module ile_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [ile_pkg::STATUS_W-1:0]     status,
    input logic signed [ile_pkg::VALUE_WIDTH-1:0] read_value,
    input logic [ile_pkg::COUNT_W-1:0]      list_length
);

    import ile_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(read_value) && $stable(list_length))
        else $error("result changed while stalled");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> list_length <= COUNT_W'(CAPACITY))
        else $error("list length beyond capacity");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> list_length == COUNT_W'(CAPACITY))
        else $error("full reported below capacity");

    // rejected commands carry either zero or the invalid-read marker
    a_reject_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> read_value == '0 || read_value == '1)
        else $error("unexpected value on rejected command");

endmodule

bind indexed_list_engine_top ile_checker u_ile_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .read_value  (read_value),
    .list_length (list_length)
);
